FILE: rtl/three_integer_line_parser_core_macros.svh
//------------------------------------------------------------------------------
// three_integer_line_parser_core_macros
// assertion macros used by the line parser checker
//------------------------------------------------------------------------------
`ifndef THREE_INTEGER_LINE_PARSER_CORE_MACROS_SVH
`define THREE_INTEGER_LINE_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define TLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line parser check failed");

// next-cycle implication
`define TLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line parser check failed");

`endif

FILE: rtl/tlp_pkg.sv
//------------------------------------------------------------------------------
// tlp_pkg
// types and constants shared by the three-integer line parser
//------------------------------------------------------------------------------
package tlp_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned COUNT_W = 2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TOK1 = 3'd1,
        PH_GAP1 = 3'd2,
        PH_TOK2 = 3'd3,
        PH_GAP2 = 3'd4,
        PH_TOK3 = 3'd5,
        PH_DONE = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [VALUE_W-1:0]   magnitude;
        logic                 negative;
        logic                 conv_stopped;
        logic                 token_start;
        logic [VALUE_W-1:0]   saved0;
        logic [VALUE_W-1:0]   saved1;
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] second_value;
        logic signed [VALUE_W-1:0] third_value;
        logic [COUNT_W-1:0]        tokens_found;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:        PH_IDLE,
        magnitude:    '0,
        negative:     1'b0,
        conv_stopped: 1'b0,
        token_start:  1'b1,
        saved0:       '0,
        saved1:       '0
    };

endpackage

FILE: rtl/three_integer_line_parser_core.sv
// result path: the terminator is registered in r_ch, then its result in r_out
// throughput: one character per cycle unless o_stall (a terminator held up by i_stall);
//   the multiply-by-ten accumulate between r_ch and the parse state sets the cycle
// reset: synchronous active-low i_rst_n clears the parse state and both valid flags
//------------------------------------------------------------------------------
// three_integer_line_parser_core
// parses up to three decimal integers from a zero-terminated character stream
//------------------------------------------------------------------------------
module three_integer_line_parser_core
    import tlp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [CH_W-1:0]           i_ch,
    output logic                      o_stall,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_first_value,
    output logic signed [VALUE_W-1:0] o_second_value,
    output logic signed [VALUE_W-1:0] o_third_value,
    output logic [COUNT_W-1:0]        o_tokens_found,
    input  logic                      i_stall
);

    logic [CH_W-1:0] r_ch;
    logic            r_ch_valid;
    t_state          r_state;
    t_state          n_state;
    t_result         r_out;
    t_result         n_out;
    logic            r_out_valid;
    logic            out_free;
    logic            step_go;
    logic            is_eol;

    tlp_char_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign is_eol   = (r_ch == '0);
    assign out_free = !r_out_valid || !i_stall;
    assign step_go  = r_ch_valid && (!is_eol || out_free);
    assign o_stall  = r_ch_valid && !step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_ch_valid <= i_valid;
            end
            if (step_go) begin
                r_state <= n_state;
            end
            if (step_go && is_eol) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_ch <= i_ch;
        end
        if (step_go && is_eol) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_value  = r_out.first_value;
    assign o_second_value = r_out.second_value;
    assign o_third_value  = r_out.third_value;
    assign o_tokens_found = r_out.tokens_found;

endmodule

FILE: rtl/tlp_char_step.sv
//------------------------------------------------------------------------------
// tlp_char_step
// next parse state for one character, and the line result on the terminator
//------------------------------------------------------------------------------
module tlp_char_step
    import tlp_pkg::*;
(
    input  t_state            i_state,
    input  logic [CH_W-1:0]   i_ch,
    output t_state            o_state,
    output t_result           o_result
);

    localparam logic [CH_W-1:0]    CH_EOL   = 8'h00;
    localparam logic [CH_W-1:0]    CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0]    CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0]    CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0]    CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0]    CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0]    CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0]    CH_NINE  = 8'h39;
    localparam logic [VALUE_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W+3:0] MAG_CAP  = 36'h0_8000_0000;

    function automatic logic [VALUE_W-1:0] cur_value(input logic [VALUE_W-1:0] mag,
                                                     input logic neg);
        if (neg) begin
            return '0 - mag;
        end
        return (mag > POS_MAX) ? POS_MAX : mag;
    endfunction

    logic               is_blank;
    logic               is_digit;
    logic               is_sign;
    logic [VALUE_W-1:0] cur;

    assign is_blank = ((i_ch >= CH_TAB) && (i_ch <= CH_CR)) || (i_ch == CH_SPACE);
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign cur      = cur_value(i_state.magnitude, i_state.negative);

    // next state
    always_comb begin
        t_state             w;
        logic [VALUE_W+3:0] prod;
        logic [3:0]         dig;
        w    = i_state;
        dig  = 4'(i_ch - CH_ZERO);
        prod = '0;
        if (i_ch == CH_EOL) begin
            w = STATE_RESET;
        end else if (i_state.phase == PH_DONE) begin
            w = i_state;
        end else if (is_blank) begin
            case (i_state.phase)
                PH_TOK1: begin
                    w.saved0 = cur;
                    w.phase  = PH_GAP1;
                end
                PH_TOK2: begin
                    w.saved1 = cur;
                    w.phase  = PH_GAP2;
                end
                PH_TOK3: begin
                    w.phase = PH_DONE;
                end
                default: begin
                    w.phase = i_state.phase;
                end
            endcase
        end else begin
            // token opens
            if (i_state.phase == PH_IDLE || i_state.phase == PH_GAP1 ||
                i_state.phase == PH_GAP2) begin
                case (i_state.phase)
                    PH_IDLE: w.phase = PH_TOK1;
                    PH_GAP1: w.phase = PH_TOK2;
                    default: w.phase = PH_TOK3;
                endcase
                w.magnitude    = '0;
                w.negative     = 1'b0;
                w.conv_stopped = 1'b0;
                w.token_start  = 1'b1;
            end
            prod = {1'b0, w.magnitude, 3'b000} + {3'b000, w.magnitude, 1'b0}
                 + {{(VALUE_W){1'b0}}, dig};
            if (w.token_start && is_sign) begin
                w.negative = (i_ch == CH_MINUS);
            end else if (!w.conv_stopped && is_digit) begin
                w.magnitude = (prod > MAG_CAP) ? MAG_CAP[VALUE_W-1:0]
                                               : prod[VALUE_W-1:0];
            end else begin
                w.conv_stopped = 1'b1;
            end
            w.token_start = 1'b0;
        end
        o_state = w;
    end

    // line result
    always_comb begin
        o_result = '0;
        case (i_state.phase)
            PH_IDLE: begin
                o_result.tokens_found = 2'd0;
            end
            PH_TOK1: begin
                o_result.first_value  = cur;
                o_result.tokens_found = 2'd1;
            end
            PH_GAP1: begin
                o_result.first_value  = i_state.saved0;
                o_result.tokens_found = 2'd1;
            end
            PH_TOK2: begin
                o_result.first_value  = i_state.saved0;
                o_result.second_value = cur;
                o_result.tokens_found = 2'd2;
            end
            PH_GAP2: begin
                o_result.first_value  = i_state.saved0;
                o_result.second_value = i_state.saved1;
                o_result.tokens_found = 2'd2;
            end
            default: begin
                o_result.first_value  = i_state.saved0;
                o_result.second_value = i_state.saved1;
                o_result.third_value  = cur;
                o_result.tokens_found = 2'd3;
            end
        endcase
    end

endmodule

FILE: rtl/tlp_checker.sv
//------------------------------------------------------------------------------
// tlp_checker
// port-level checks on the line parser results
//------------------------------------------------------------------------------
`include "three_integer_line_parser_core_macros.svh"

module tlp_checker
    import tlp_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic [CH_W-1:0]           i_ch,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic signed [VALUE_W-1:0] o_first_value,
    input logic signed [VALUE_W-1:0] o_second_value,
    input logic signed [VALUE_W-1:0] o_third_value,
    input logic [COUNT_W-1:0]        o_tokens_found,
    input logic                      i_stall
);

    logic                         eol_xfer;
    logic                         out_wait;
    logic                         none_found;
    logic                         below_two;
    logic                         below_three;
    logic [3*VALUE_W+COUNT_W-1:0] out_word;

    assign eol_xfer    = i_valid && !o_stall && (i_ch == '0);
    assign out_wait    = o_valid && i_stall;
    assign none_found  = o_valid && (o_tokens_found == 2'd0);
    assign below_two   = o_valid && (o_tokens_found < 2'd2);
    assign below_three = o_valid && (o_tokens_found != 2'd3);
    assign out_word    = {o_first_value, o_second_value, o_third_value, o_tokens_found};

    `TLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(out_word))
    `TLP_ASSERT_NOW(a_no_tokens_zero, i_clk, i_rst_n, none_found, o_first_value == 0)
    `TLP_ASSERT_NOW(a_second_absent, i_clk, i_rst_n, below_two, o_second_value == 0)
    `TLP_ASSERT_NOW(a_third_absent, i_clk, i_rst_n, below_three, o_third_value == 0)
    `TLP_ASSERT_NOW(a_result_after_eol, i_clk, i_rst_n, $rose(o_valid), $past(eol_xfer, 2))

endmodule

bind three_integer_line_parser_core tlp_checker u_tlp_checker (.*);

FILE: dv/tb_three_integer_line_parser_core.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_three_integer_line_parser_core
// Character lines are streamed into the parser, each one closed by a zero
// byte. A scoreboard follows every accepted character with its own parse
// state and queues the values and token count due at each line end. Each
// result the block hands out is checked against the oldest queued line.
// Directed lines hit the limits first. Random lines come next, mostly
// well-formed, with noise in between. Both sides of the block pause at
// random.
//------------------------------------------------------------------------------
module tb_three_integer_line_parser_core
    import tlp_pkg::*;
();

    localparam logic [CH_W-1:0]    END_OF_LINE = 8'h00;
    localparam logic [CH_W-1:0]    CH_SPACE    = 8'h20;
    localparam logic [CH_W-1:0]    CH_TAB      = 8'h09;
    localparam logic [CH_W-1:0]    CH_CR       = 8'h0D;
    localparam logic [CH_W-1:0]    CH_PLUS     = "+";
    localparam logic [CH_W-1:0]    CH_MINUS    = "-";
    localparam logic [CH_W-1:0]    CH_ZERO     = "0";
    localparam logic [CH_W-1:0]    CH_NINE     = "9";
    localparam logic [VALUE_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] MAG_CAP     = 32'h8000_0000;
    localparam int                 ITEM_GOAL   = 1800;

    class line_scoreboard;
        t_phase             phase;
        logic [VALUE_W-1:0] magnitude;
        bit                 negative;
        bit                 stopped;
        bit                 token_start;
        logic [VALUE_W-1:0] saved0;
        logic [VALUE_W-1:0] saved1;
        t_result            expected_lines[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_IDLE;
            magnitude   = '0;
            negative    = 1'b0;
            stopped     = 1'b0;
            token_start = 1'b1;
            saved0      = '0;
            saved1      = '0;
        endfunction

        function logic [VALUE_W-1:0] token_value();
            if (negative) begin
                return -magnitude;
            end
            return (magnitude > INT_MAX) ? INT_MAX : magnitude;
        endfunction

        // advance the parse by one accepted character
        function void note_char(logic [CH_W-1:0] c);
            t_result           line;
            logic [VALUE_W+3:0] acc;
            if (c == END_OF_LINE) begin
                line = '0;
                line.tokens_found = COUNT_W'((int'(phase) + 1) >> 1);
                case (phase)
                    PH_TOK1: begin
                        line.first_value = token_value();
                    end
                    PH_GAP1: begin
                        line.first_value = saved0;
                    end
                    PH_TOK2: begin
                        line.first_value  = saved0;
                        line.second_value = token_value();
                    end
                    PH_GAP2: begin
                        line.first_value  = saved0;
                        line.second_value = saved1;
                    end
                    PH_TOK3, PH_DONE: begin
                        line.first_value  = saved0;
                        line.second_value = saved1;
                        line.third_value  = token_value();
                    end
                    default: begin
                    end
                endcase
                expected_lines.push_back(line);
                restart();
                return;
            end
            if (phase == PH_DONE) begin
                return;
            end
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (phase inside {PH_TOK1, PH_TOK2, PH_TOK3}) begin
                    if (phase == PH_TOK1) begin
                        saved0 = token_value();
                    end else if (phase == PH_TOK2) begin
                        saved1 = token_value();
                    end
                    phase = t_phase'(phase + 3'd1);
                end
                return;
            end
            if (!(phase inside {PH_TOK1, PH_TOK2, PH_TOK3})) begin
                phase       = t_phase'(phase + 3'd1);
                magnitude   = '0;
                negative    = 1'b0;
                stopped     = 1'b0;
                token_start = 1'b1;
            end
            if (token_start && (c == CH_PLUS || c == CH_MINUS)) begin
                negative = (c == CH_MINUS);
            end else if (!stopped && c >= CH_ZERO && c <= CH_NINE) begin
                acc = {4'b0, magnitude} * 36'd10 + 36'(c - CH_ZERO);
                magnitude = (acc > 36'(MAG_CAP)) ? MAG_CAP : acc[VALUE_W-1:0];
            end else begin
                stopped = 1'b1;
            end
            token_start = 1'b0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic signed [VALUE_W-1:0] first_value,
                          logic signed [VALUE_W-1:0] second_value,
                          logic signed [VALUE_W-1:0] third_value,
                          logic [COUNT_W-1:0]        tokens_found);
            t_result want;
            if (expected_lines.size() == 0) begin
                report_mismatch("result transfer with no line end pending");
                return;
            end
            want = expected_lines.pop_front();
            if (first_value !== want.first_value) begin
                report_mismatch($sformatf("first_value %0d, want %0d",
                                          first_value, want.first_value));
            end
            if (second_value !== want.second_value) begin
                report_mismatch($sformatf("second_value %0d, want %0d",
                                          second_value, want.second_value));
            end
            if (third_value !== want.third_value) begin
                report_mismatch($sformatf("third_value %0d, want %0d",
                                          third_value, want.third_value));
            end
            if (tokens_found !== want.tokens_found) begin
                report_mismatch($sformatf("tokens_found %0d, want %0d",
                                          tokens_found, want.tokens_found));
            end
        endtask
    endclass

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic [CH_W-1:0]           i_ch    = '0;
    logic                      i_stall = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_first_value;
    logic signed [VALUE_W-1:0] o_second_value;
    logic signed [VALUE_W-1:0] o_third_value;
    logic [COUNT_W-1:0]        o_tokens_found;

    line_scoreboard   sb;
    logic [CH_W-1:0]  line_buf[$];
    int               burst_left = 0;
    int               sent_count = 0;
    int               stall_left = 0;
    int               stall_mode = 0;
    int               stall_tick = 0;

    three_integer_line_parser_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_ch           (i_ch),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_third_value  (o_third_value),
        .o_tokens_found (o_tokens_found),
        .i_stall        (i_stall)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watch both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_char(i_ch);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_first_value, o_second_value, o_third_value,
                                o_tokens_found);
            end
        end
    end

    // result side back-pressure; the mode changes after a run of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 300);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    task automatic send_char(input logic [CH_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_ch    <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_line();
        foreach (line_buf[k]) begin
            send_char(line_buf[k]);
        end
        send_char(END_OF_LINE);
        line_buf.delete();
    endtask

    function automatic void add_text(string s);
        foreach (s[k]) begin
            line_buf.push_back(s[k]);
        end
    endfunction

    function automatic void add_blanks(int lo, int hi);
        int n;
        logic [CH_W-1:0] c;
        n = $urandom_range(lo, hi);
        repeat (n) begin
            c = CH_W'($urandom_range(8, 13));
            line_buf.push_back((c == 8'd8) ? CH_SPACE : c);
        end
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 9))
            0: return "2147483647";
            1: return "2147483648";
            2: return "99999999999";
            3: return "0";
            4: return $sformatf("000%0d", $urandom_range(0, 99));
            5: return $sformatf("%0d%0d", $urandom, $urandom_range(0, 9));
            default: return $sformatf("%0d", $urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    function automatic void add_token();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_MINUS);
            1: line_buf.push_back(CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 9) != 0) begin
            add_text(number_text());
        end
        if ($urandom_range(0, 5) == 0) begin
            // any non-blank, non-zero character, signs and high codes included
            do begin
                c = CH_W'($urandom_range(1, 255));
            end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
            line_buf.push_back(c);
            if ($urandom_range(0, 1) == 0) begin
                add_text(number_text());
            end
        end
    endfunction

    initial begin
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty line, then a lone sign ended by the line end
        send_line();
        add_text("-");
        send_line();
        // high code stops a token, sign inside a token, negative overflow at line end
        add_text("+9");
        line_buf.push_back(8'h80);
        add_text(" 1-2 -99999999999");
        send_line();
        // every blank code, positive overflow, text after the third token
        line_buf.push_back(CH_TAB);
        line_buf.push_back(8'h0B);
        add_text("4294967296");
        line_buf.push_back(8'h0A);
        line_buf.push_back(8'h0C);
        line_buf.push_back(CH_CR);
        add_text(" x 7 7 -");
        send_line();
        // range limits, line ends between tokens
        add_text("2147483648 -2147483648 ");
        send_line();
        line_buf.push_back(8'hFF);
        add_text("7 ");
        send_line();

        while (sent_count < ITEM_GOAL) begin
            if ($urandom_range(0, 9) < 8) begin
                add_blanks(0, 2);
                n = $urandom_range(0, 5);
                for (int t = 0; t < n; t++) begin
                    if (t > 0) begin
                        add_blanks(1, 3);
                    end
                    add_token();
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_blanks(1, 2);
                end
            end else begin
                n = $urandom_range(0, 12);
                repeat (n) line_buf.push_back(CH_W'($urandom_range(1, 255)));
            end
            send_line();
        end
        i_valid <= 1'b0;

        while (sb.expected_lines.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d lines pending", sb.expected_lines.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
